@@ src/sida_pkg.sv @@
// ---------------------------------------------------------------------------
// sida_pkg: shared types, constants and microcode for the decimal text block
// Control word layout, step program, datapath control/status structs.
// ---------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam int NumBits     = 32;
  localparam int DigitW      = 4;
  localparam int NumDigits   = 10;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = NumBits / BitsPerStep;
  localparam int CntW        = $clog2(ConvSteps);
  localparam int IdxW        = $clog2(NumDigits);
  localparam int CharW       = 8;
  localparam int BcdW        = NumDigits * DigitW;

  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharNine  = 8'd57;

  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;

  // step counter
  typedef logic [1:0] pc_t;
  localparam pc_t StepIdle = 2'd0;
  localparam pc_t StepConv = 2'd1;
  localparam pc_t StepSign = 2'd2;
  localparam pc_t StepEmit = 2'd3;

  typedef enum logic [1:0] {
    ActLoad,   // take a number, split sign and magnitude
    ActConv,   // four shift-add-3 steps
    ActSign,   // '-' if negative, find leading digit
    ActEmit    // one digit, walk down
  } act_t;

  typedef enum logic [1:0] {
    WaitNone,
    WaitIn,
    WaitOut
  } wt_sel_t;

  typedef enum logic [1:0] {
    CondAlways,
    CondMoreBits,
    CondMoreDigits
  } cond_t;

  typedef struct packed {
    act_t    act;
    wt_sel_t wt_sel;
    cond_t   cond;
    pc_t     tgt_t;
    pc_t     tgt_f;
  } ucode_t;

  typedef struct packed {
    logic fire;
    act_t act;
  } dp_ctrl_t;

  typedef struct packed {
    logic             neg;
    logic             more_bits;
    logic             more_digits;
    logic [CharW-1:0] ch;
    logic             last;
  } dp_stat_t;

  // program ROM
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uw;
    case (pc)
      StepIdle: uw = '{ActLoad, WaitIn,   CondAlways,     StepConv, StepConv};
      StepConv: uw = '{ActConv, WaitNone, CondMoreBits,   StepConv, StepSign};
      StepSign: uw = '{ActSign, WaitOut,  CondAlways,     StepEmit, StepEmit};
      StepEmit: uw = '{ActEmit, WaitOut,  CondMoreDigits, StepEmit, StepIdle};
      default:  uw = '{ActLoad, WaitIn,   CondAlways,     StepConv, StepConv};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

@@ src/sida_dpath.sv @@
// ---------------------------------------------------------------------------
// sida_dpath: conversion datapath
// Magnitude shift register, BCD accumulator (double dabble, 4 bits a step),
// digit pointer and character select.
// ---------------------------------------------------------------------------
`default_nettype none

module sida_dpath
  import sida_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [NumBits-1:0] number,
  input  wire dp_ctrl_t           ctrl,
  output dp_stat_t                stat
);

  logic               neg;
  logic [NumBits-1:0] mag;
  bcd_t               bcd;
  logic [CntW-1:0]    cnt;
  logic [IdxW-1:0]    idx;

  bcd_t               bcd_next;
  logic [NumBits-1:0] mag_next;
  logic [IdxW-1:0]    lead;

  // shift-add-3 over BitsPerStep bits
  always_comb begin
    bcd_t               b;
    logic [NumBits-1:0] m;
    logic [BcdW-1:0]    flat;
    logic               carry;
    b = bcd;
    m = mag;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      carry = m[NumBits-1];
      m     = {m[NumBits-2:0], 1'b0};
      flat  = b;
      flat  = {flat[BcdW-2:0], carry};
      b     = flat;
    end
    bcd_next = b;
    mag_next = m;
  end

  // highest nonzero digit, zero if none
  always_comb begin
    lead = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[d] != '0) begin
        lead = IdxW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.act)
        ActLoad: begin
          neg <= number[NumBits-1];
          mag <= number[NumBits-1] ? (NumBits'(0) - number) : number;
          bcd <= '0;
          cnt <= '0;
        end
        ActConv: begin
          bcd <= bcd_next;
          mag <= mag_next;
          cnt <= cnt + 1'b1;
        end
        ActSign: begin
          idx <= lead;
        end
        ActEmit: begin
          idx <= idx - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.neg         = neg;
    stat.more_bits   = (cnt != CntW'(ConvSteps - 1));
    stat.more_digits = (idx != '0);
    stat.ch          = (ctrl.act == ActSign) ? CharMinus : (CharZero + {4'b0, bcd[idx]});
    stat.last        = (ctrl.act == ActEmit) && (idx == '0);
  end

endmodule

`default_nettype wire

@@ src/signed_int_to_decimal_ascii.sv @@
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed value to decimal ASCII text
// Microcoded sequencer over a double-dabble datapath; one character per word.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ---------------------------------
//  in       in   in_valid / in_stall   number[31:0] (signed)
//  out      out  out_valid / out_stall ascii_char[7:0], is_last
//
// Steps: 1 load step, 8 conversion steps of 4 bits each in the BCD unit,
// 1 sign step (sends '-' for a negative number, idle otherwise), then one
// digit per cycle for D = 1..10 digits while the output side does not stall.
// Output words sit in an output register; the sign and digit steps only
// move on while that register is empty or being taken in the same cycle.
// Reset: clears the step counter and the output valid; datapath needs none.
// in_stall is high whenever the program is away from its idle step.
//
`default_nettype none

module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [NumBits-1:0] number,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CharW-1:0]        ascii_char,
  output logic                    is_last
);

  pc_t      pc;
  pc_t      pc_next;
  ucode_t   uw;
  logic     go;
  logic     cond_val;
  logic     out_free;
  logic     load_out;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign uw       = ucode_rom(pc);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (pc != StepIdle);

  // step executes once its wait condition is met
  always_comb begin
    case (uw.wt_sel)
      WaitNone: go = 1'b1;
      WaitIn:   go = in_valid;
      WaitOut:  go = out_free;
      default:  go = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      CondAlways:     cond_val = 1'b1;
      CondMoreBits:   cond_val = stat.more_bits;
      CondMoreDigits: cond_val = stat.more_digits;
      default:        cond_val = 1'b0;
    endcase
  end

  assign pc_next   = go ? (cond_val ? uw.tgt_t : uw.tgt_f) : pc;
  assign ctrl.fire = go;
  assign ctrl.act  = uw.act;

  // sign step writes '-' only for negative numbers
  assign load_out = go && ((uw.act == ActEmit) || ((uw.act == ActSign) && stat.neg));

  sida_dpath u_dpath (
    .clk    (clk),
    .number (number),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= StepIdle;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (load_out) begin
      ascii_char <= stat.ch;
      is_last    <= stat.last;
    end
  end

  // only '-' or a digit ever goes out
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == CharMinus) ||
                  ((ascii_char >= CharZero) && (ascii_char <= CharNine)))
    else $error("output word is not '-' or a digit");

  // a minus sign never closes a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ascii_char == CharMinus)) |-> !is_last)
    else $error("minus sign flagged as last");

  // a new number is only taken once the previous text is complete
  a_accept_closed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(out_valid && !is_last))
    else $error("number accepted while text still open");

  // a conversion step is always followed by conversion or the sign step
  a_conv_flow: assert property (@(posedge clk) disable iff (rst)
    (pc == StepConv) |=> ((pc == StepConv) || (pc == StepSign)))
    else $error("conversion left to wrong step");

endmodule

`default_nettype wire

@@ bench/signed_int_to_decimal_ascii_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: bench for the signed decimal text block
// A directed set of corner values comes first, then about 120 random values
// spread over every digit count. Random idle bursts are placed on both
// channels. Each character that leaves the block is checked against a text
// queue, which an independent predictor fills when a value is taken in.
// ---------------------------------------------------------------------------

import sida_pkg::*;

typedef struct packed {
  logic [CharW-1:0] ch;
  logic             last;
} text_char_t;

// Expected text for every value taken in, oldest first.
class text_scoreboard;
  text_char_t expected_text[$];
  int         fail_count;

  // Decimal text of a 32-bit two's complement value. The magnitude is held
  // unsigned, so the most negative value comes out as 2147483648.
  function void note_number(logic [NumBits-1:0] value);
    localparam int unsigned Radix = 10;
    logic [NumBits-1:0] mag;
    logic [CharW-1:0]   digits[$];
    text_char_t         tc;
    mag = value[NumBits-1] ? (32'd0 - value) : value;
    if (mag == 0) begin
      digits.push_front(CharZero);
    end else begin
      while (mag != 0) begin
        digits.push_front(CharZero + CharW'(mag % Radix));
        mag = mag / Radix;
      end
    end
    if (value[NumBits-1]) begin
      tc.ch   = CharMinus;
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    foreach (digits[k]) begin
      tc.ch   = digits[k];
      tc.last = (k == digits.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  function void check_char(logic [CharW-1:0] ch, logic last);
    text_char_t exp_c;
    if (expected_text.size() == 0) begin
      $display("%0t: unexpected char got %0d last %0b", $time, ch, last);
      fail_count++;
    end else begin
      exp_c = expected_text.pop_front();
      if (exp_c.ch !== ch) begin
        $display("%0t: ascii_char expected %0d got %0d", $time, exp_c.ch, ch);
        fail_count++;
      end
      if (exp_c.last !== last) begin
        $display("%0t: is_last expected %0b got %0b", $time, exp_c.last, last);
        fail_count++;
      end
    end
  endfunction

  function int pending();
    return expected_text.size();
  endfunction
endclass

module signed_int_to_decimal_ascii_test;

  localparam int CycleLimit  = 200000;
  localparam int RandomCount = 120;
  localparam int QuietFrom   = 100;   // last stretch runs with no idling
  localparam int DrainCycles = 30;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [NumBits-1:0] number     = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [CharW-1:0]   ascii_char;
  logic               is_last;

  text_scoreboard text_sb;
  int             idle_odds;       // 0: no idling, else 1-in-N burst start
  int             stall_left;
  int             cycle_count;

  signed_int_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ascii_char(ascii_char),
    .is_last   (is_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops characters.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Watch both channels at the edge (values here are the pre-edge ones, so
  // the order of processes in this step does not matter). The receiver's
  // stall bursts are also generated here.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) text_sb.note_number(number);
      if (out_valid && !out_stall) text_sb.check_char(ascii_char, is_last);
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      stall_left = $urandom_range(10, 1);
    end
    out_stall <= (stall_left > 0);
  end

  // Offer one word; maybe after an idle burst. Returns once it is taken.
  task automatic send_number(input logic [NumBits-1:0] value);
    int gap;
    if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      gap = $urandom_range(10, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender back until every expected character has come out.
  // One edge first, so the word taken at the last edge is already noted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (text_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [NumBits-1:0] corner[$];
    logic [NumBits-1:0] value;
    logic [NumBits-1:0] mag;
    longint             lo;
    longint             hi;
    int                 ndig;

    text_sb     = new();
    idle_odds   = 3;
    stall_left  = 0;
    cycle_count = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Corner values: zero, one digit, digit-count edges, both ends of the
    // range (most negative is the 11-char case), alternating bit patterns.
    corner = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, 32'd99, 32'd100,
               -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
               32'd1000000000, 32'd999999999, -32'sd1000000000, 32'h5555_5555,
               32'hAAAA_AAAA, 32'd123456789, -32'sd987654321, 32'd7,
               32'd2147483640, 32'd65536};
    foreach (corner[i]) send_number(corner[i]);
    wait_drained();

    for (int i = 0; i < RandomCount; i++) begin
      // idling mix changes every ten words; some stretches have none
      if (i % 10 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_odds = 0;
          1:       idle_odds = 2;
          default: idle_odds = 5;
        endcase
      end
      if (i >= QuietFrom) idle_odds = 0;
      if (i == RandomCount / 2) wait_drained();

      if ($urandom_range(7, 0) == 0) begin
        value = $urandom();
      end else begin
        // pick a digit count first so short and long texts are both common
        ndig = $urandom_range(10, 1);
        lo   = longint'(10) ** (ndig - 1);
        hi   = longint'(10) ** ndig - 1;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag  = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(1, 0) == 1) begin
          value = 32'd0 - mag;
        end else begin
          value = (mag == 32'h8000_0000) ? 32'h7FFF_FFFF : mag;
        end
      end
      send_number(value);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (text_sb.fail_count == 0 && text_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
